// ===== src/lsfb_pkg.sv =====
// shared constants, stage map, lane type and the exp(-k) table builder
`default_nettype none

package lsfb_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ACC_BITS      = 30;
   localparam int EXP_TERMS     = 14;
   localparam int LN_TERMS      = 10;
   localparam int K_CAP         = 32;
   localparam int DIV_STEPS     = 31;

   // stage map
   localparam int EXP0   = 1;
   localparam int U_ST   = EXP0 + 2 * EXP_TERMS;
   localparam int DIV0   = U_ST + 1;
   localparam int Z2_ST  = DIV0 + DIV_STEPS;
   localparam int LN0    = Z2_ST + 1;
   localparam int GM_ST  = LN0 + 2 * LN_TERMS;
   localparam int OUT_ST = GM_ST + 1;
   localparam int N_ST   = OUT_ST + 1;

   typedef logic [30:0] ek_tab_type [0:K_CAP];

   typedef struct packed {
      logic        neg;
      logic [23:0] a;
      logic        gneg;
      logic [23:0] gm;
      logic [29:0] t;
      logic [30:0] ek;
      logic [30:0] prod;
      logic [30:0] term;
      logic [30:0] sum;
      logic [30:0] u;
      logic [31:0] z_rem;
      logic [30:0] z_q;
      logic [31:0] s_rem;
      logic [30:0] s_q;
      logic [30:0] z2;
      logic [30:0] p;
      logic [30:0] lsum;
      logic [54:0] gp;
      logic [23:0] y;
      logic [23:0] grad;
   } lane_type;

   // exp(-k) for k = 0..K_CAP in Q.30, built at elaboration by long division
   function automatic ek_tab_type build_ek_table();
      longint unsigned term;
      longint unsigned sum;
      longint unsigned num;
      longint unsigned q;
      longint unsigned rem;
      longint unsigned e1;
      longint unsigned ek;
      ek_tab_type      tab;
      term = 64'd1 << ACC_BITS;
      sum  = 64'd1 << ACC_BITS;
      for (int i = 1; i <= EXP_TERMS; i++) begin
         num = (term * (64'd1 << (ACC_BITS - 1))) >> ACC_BITS;
         q   = 64'd0;
         rem = 64'd0;
         for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | longint'(num[b]);
            q   = q << 1;
            if (rem >= longint'(i)) begin
               rem = rem - longint'(i);
               q   = q | 64'd1;
            end
         end
         term = q;
         if ((i % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      e1 = (sum * sum) >> ACC_BITS;
      ek = 64'd1 << ACC_BITS;
      for (int k = 0; k <= K_CAP; k++) begin
         tab[k] = ek[30:0];
         ek     = (ek * e1) >> ACC_BITS;
      end
      return tab;
   endfunction

endpackage

`default_nettype wire

// ===== src/log_sigmoid_forward_backward_core.sv =====
// log-sigmoid unit: forward value and backward gradient, one transaction per cycle unless the output is held
// 84 register stages lie between the req transaction and rsp_valid
// throughput: one transaction per cycle; the whole pipe advances unless the output is held
// exp series, two 31-step restoring dividers and the ln series each take one stage per step
// reset clears all stage valid bits; data registers are not reset
`default_nettype none

module log_sigmoid_forward_backward_core #(
   parameter int FRAC_BITS = lsfb_pkg::FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [23:0] req_x_value,
   input  wire logic [23:0] req_grad_out,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [23:0]      rsp_y_value,
   output logic [23:0]      rsp_grad_in
);

   localparam int N   = lsfb_pkg::N_ST;
   localparam int SH  = lsfb_pkg::ACC_BITS - FRAC_BITS;
   localparam int MW  = 24 + SH + 2;
   localparam logic [23:0] FRAC_MASK = 24'((64'd1 << FRAC_BITS) - 64'd1);
   localparam lsfb_pkg::ek_tab_type EK_ROM = lsfb_pkg::build_ek_table();

   lsfb_pkg::lane_type stage_ff [0:N-1];
   lsfb_pkg::lane_type stage_in [0:N-1];
   logic [N-1:0]       vld_ff;
   logic               adv;

   assign adv       = !vld_ff[N-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[N-1];
   assign rsp_y_value = stage_ff[N-1].y;
   assign rsp_grad_in = stage_ff[N-1].grad;

   // input stage: magnitudes, integer part lookup, fraction to Q.30
   logic [23:0] in_a;
   logic [23:0] in_k;
   logic [5:0]  in_kc;
   always_comb begin
      in_a  = req_x_value[23] ? (~req_x_value + 24'd1) : req_x_value;
      in_k  = in_a >> FRAC_BITS;
      in_kc = (in_k > 24'(lsfb_pkg::K_CAP)) ? 6'(lsfb_pkg::K_CAP) : in_k[5:0];
      stage_in[0]      = '0;
      stage_in[0].neg  = req_x_value[23];
      stage_in[0].a    = in_a;
      stage_in[0].gneg = req_grad_out[23];
      stage_in[0].gm   = req_grad_out[23] ? (~req_grad_out + 24'd1) : req_grad_out;
      stage_in[0].t    = 30'(in_a & FRAC_MASK) << SH;
      stage_in[0].ek   = EK_ROM[in_kc];
      stage_in[0].term = 31'h40000000;
      stage_in[0].sum  = 31'h40000000;
   end

   for (genvar j = 1; j < N; j++) begin : g_st
      if (j < lsfb_pkg::U_ST) begin : g_exp
         localparam int I = (j - lsfb_pkg::EXP0) / 2 + 1;
         if (((j - lsfb_pkg::EXP0) % 2) == 0) begin : g_mul
            logic [60:0] mul;
            always_comb begin
               mul = 61'(stage_ff[j-1].term) * 61'(stage_ff[j-1].t);
               stage_in[j]      = stage_ff[j-1];
               stage_in[j].prod = mul[60:30];
            end
         end else begin : g_rcp
            localparam int S = 31 + $clog2(I);
            localparam logic [31:0] M = 32'(((64'd1 << S) + 64'(I) - 64'd1) / 64'(I));
            logic [62:0] rcp;
            logic [30:0] q;
            always_comb begin
               rcp = 63'(stage_ff[j-1].prod) * 63'(M);
               q   = 31'(rcp >> S);
               stage_in[j]      = stage_ff[j-1];
               stage_in[j].term = q;
               if ((I % 2) == 1) begin
                  stage_in[j].sum = stage_ff[j-1].sum - q;
               end else begin
                  stage_in[j].sum = stage_ff[j-1].sum + q;
               end
            end
         end
      end else if (j == lsfb_pkg::U_ST) begin : g_u
         logic [61:0] mul;
         logic [30:0] u;
         always_comb begin
            mul = 62'(stage_ff[j-1].ek) * 62'(stage_ff[j-1].sum);
            u   = mul[60:30];
            stage_in[j]       = stage_ff[j-1];
            stage_in[j].u     = u;
            stage_in[j].z_rem = 32'(u >> 1);
            stage_in[j].s_rem = stage_ff[j-1].neg ? 32'h20000000 : 32'(u >> 1);
            stage_in[j].z_q   = '0;
            stage_in[j].s_q   = '0;
         end
      end else if (j < lsfb_pkg::Z2_ST) begin : g_div
         localparam int STEP = j - lsfb_pkg::DIV0;
         logic        bz;
         logic        bs;
         logic [32:0] rz;
         logic [32:0] rs;
         logic [32:0] dz;
         logic [32:0] ds;
         always_comb begin
            bz = (STEP == 0) ? stage_ff[j-1].u[0] : 1'b0;
            bs = (STEP == 0 && !stage_ff[j-1].neg) ? stage_ff[j-1].u[0] : 1'b0;
            rz = {stage_ff[j-1].z_rem, bz};
            rs = {stage_ff[j-1].s_rem, bs};
            dz = 33'h080000000 + 33'(stage_ff[j-1].u);
            ds = 33'h040000000 + 33'(stage_ff[j-1].u);
            stage_in[j] = stage_ff[j-1];
            if (rz >= dz) begin
               stage_in[j].z_rem = 32'(rz - dz);
               stage_in[j].z_q   = {stage_ff[j-1].z_q[29:0], 1'b1};
            end else begin
               stage_in[j].z_rem = 32'(rz);
               stage_in[j].z_q   = {stage_ff[j-1].z_q[29:0], 1'b0};
            end
            if (rs >= ds) begin
               stage_in[j].s_rem = 32'(rs - ds);
               stage_in[j].s_q   = {stage_ff[j-1].s_q[29:0], 1'b1};
            end else begin
               stage_in[j].s_rem = 32'(rs);
               stage_in[j].s_q   = {stage_ff[j-1].s_q[29:0], 1'b0};
            end
         end
      end else if (j == lsfb_pkg::Z2_ST) begin : g_z2
         logic [61:0] mul;
         always_comb begin
            mul = 62'(stage_ff[j-1].z_q) * 62'(stage_ff[j-1].z_q);
            stage_in[j]      = stage_ff[j-1];
            stage_in[j].z2   = mul[60:30];
            stage_in[j].p    = stage_ff[j-1].z_q;
            stage_in[j].lsum = stage_ff[j-1].z_q;
         end
      end else if (j < lsfb_pkg::GM_ST) begin : g_ln
         localparam int I = 2 * ((j - lsfb_pkg::LN0) / 2 + 1) + 1;
         if (((j - lsfb_pkg::LN0) % 2) == 0) begin : g_mul
            logic [61:0] mul;
            always_comb begin
               mul = 62'(stage_ff[j-1].p) * 62'(stage_ff[j-1].z2);
               stage_in[j]   = stage_ff[j-1];
               stage_in[j].p = mul[60:30];
            end
         end else begin : g_rcp
            localparam int S = 31 + $clog2(I);
            localparam logic [31:0] M = 32'(((64'd1 << S) + 64'(I) - 64'd1) / 64'(I));
            logic [62:0] rcp;
            always_comb begin
               rcp = 63'(stage_ff[j-1].p) * 63'(M);
               stage_in[j]      = stage_ff[j-1];
               stage_in[j].lsum = stage_ff[j-1].lsum + 31'(rcp >> S);
            end
         end
      end else if (j == lsfb_pkg::GM_ST) begin : g_gm
         logic [MW-1:0] mag;
         logic [MW-1:0] ymr;
         logic [23:0]   ymc;
         always_comb begin
            mag = (stage_ff[j-1].neg ? (MW'(stage_ff[j-1].a) << SH) : '0)
                  + MW'({stage_ff[j-1].lsum, 1'b0});
            ymr = (mag + (MW'(1) << (SH - 1))) >> SH;
            ymc = (ymr > MW'(24'h800000)) ? 24'h800000 : ymr[23:0];
            stage_in[j]    = stage_ff[j-1];
            stage_in[j].gp = 55'(stage_ff[j-1].gm) * 55'(stage_ff[j-1].s_q);
            stage_in[j].y  = 24'd0 - ymc;
         end
      end else begin : g_out
         logic [55:0] rnd;
         logic [25:0] pm;
         always_comb begin
            rnd = 56'(stage_ff[j-1].gp) + 56'h20000000;
            pm  = rnd[55:30];
            stage_in[j] = stage_ff[j-1];
            if (stage_ff[j-1].gneg) begin
               stage_in[j].grad = (pm > 26'h800000) ? 24'h800000 : (24'd0 - pm[23:0]);
            end else begin
               stage_in[j].grad = (pm > 26'h7FFFFF) ? 24'h7FFFFF : pm[23:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_reset_clears: assert property (@(posedge clock) reset |=> (vld_ff == '0))
      else $error("stage valid bits not cleared by reset");
   a_y_nonpos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_y_value[23] || rsp_y_value == 24'd0))
      else $error("log-sigmoid result is positive");
   a_hold_valids: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipe moved while held");
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[lsfb_pkg::U_ST] |-> (stage_ff[lsfb_pkg::U_ST].u <= 31'h40000000))
      else $error("exp(-|x|) above one");
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[lsfb_pkg::Z2_ST - 1] |->
      (stage_ff[lsfb_pkg::Z2_ST - 1].s_q <= 31'h40000000 &&
       stage_ff[lsfb_pkg::Z2_ST - 1].z_q < 31'h20000000))
      else $error("divider quotient out of range");
`endif

endmodule

`default_nettype wire
